FILE: src/imu_ufr_pkg.sv
// Shared types and constants for the IMU serial frame receiver.
// No dependencies; imported by the byte cell, the top level, the checker and the testbench.
package imu_ufr_pkg;

    localparam int BYTE_W       = 8;
    localparam int POS_W        = 5;
    localparam int KEPT_LEN     = 13;    // index byte plus twelve value bytes
    localparam int SUM_LEN      = 16;    // bytes covered by the checksum
    localparam int HEADER_W     = 16;
    localparam logic [HEADER_W-1:0] HEADER_RESET = 16'hAAAA;

    typedef enum logic [1:0] {
        STAT_HDR_OK   = 2'd0,
        STAT_HDR_ERR  = 2'd1,
        STAT_CHK_GOOD = 2'd2,
        STAT_CHK_ERR  = 2'd3
    } status_t;

endpackage

FILE: src/imu_uart_frame_receiver.sv
// Top level of the IMU serial frame receiver: header hunt, checksum and latch.
// Depends on imu_ufr_pkg and imu_ufr_cell (payload shift line).
//
// Usage:
//   Input channel: rx_byte with in_valid / in_stall, one serial byte per item.
//   Output channel: status and the last-good-frame fields with out_valid /
//   out_stall. A result leaves for the second byte of each header pair and
//   for the checksum byte of each frame; other bytes give no result.
//   cfg_write_en / cfg_write_data write the expected header (first byte in
//   the low half); write it only while the block is idle.
// Timing:
//   One byte per cycle while in_stall is low. A result shows on out_valid in the
//   cycle after its byte is accepted. The first 13 payload bytes move one cell
//   along a 13-cell shift line per accepted byte; the checksum sums all 16.
// Reset:
//   The block hunts for a header, the header register reads 0xAAAA and all
//   latched fields read zero.
// Stall:
//   A waiting result is held in the output register. Bytes that cause no
//   result are still accepted; in_stall rises only for a byte that would
//   produce a result while the previous one is still waiting.
module imu_uart_frame_receiver
    import imu_ufr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [HEADER_W-1:0]  cfg_write_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [7:0]           frame_index,
    output logic signed [16:0]   yaw_out,
    output logic signed [15:0]   pitch_out,
    output logic signed [15:0]   roll_out,
    output logic signed [15:0]   accel_x_out,
    output logic signed [15:0]   accel_y_out,
    output logic signed [15:0]   accel_z_out
);

    logic [HEADER_W-1:0] header_reg;
    logic                hunting_reg, hunting_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   first_reg, first_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic                latch_en;

    logic [BYTE_W-1:0]   index_reg;
    logic signed [16:0]  yaw_reg;
    logic signed [15:0]  pitch_reg, roll_reg, ax_reg, ay_reg, az_reg;

    logic                accept, will_emit, shift_en;
    logic [BYTE_W-1:0]   cell_q [KEPT_LEN];

    // Byte k of the frame body sits in cell KEPT_LEN-1-k once all cells are full.
    function automatic logic signed [15:0] word_at(input logic [BYTE_W-1:0] lo,
                                                   input logic [BYTE_W-1:0] hi);
        return signed'({hi, lo});
    endfunction

    assign will_emit = hunting_reg ? (pos_reg == POS_W'(1)) : (pos_reg == POS_W'(SUM_LEN));
    assign in_stall  = out_valid_reg && out_stall && will_emit;
    assign accept    = in_valid && !in_stall;
    assign shift_en  = accept && !hunting_reg && (pos_reg < POS_W'(KEPT_LEN));

    // Payload shift line
    generate
        for (genvar i = 0; i < KEPT_LEN; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                imu_ufr_cell u_cell (
                    .clk   (clk),
                    .shift (shift_en),
                    .d     (rx_byte),
                    .q     (cell_q[i])
                );
            end
            else
            begin : g_body
                imu_ufr_cell u_cell (
                    .clk   (clk),
                    .shift (shift_en),
                    .d     (cell_q[i-1]),
                    .q     (cell_q[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        hunting_next   = hunting_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        sum_next       = sum_reg;
        status_next    = status_reg;
        latch_en       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        if (accept)
        begin
            if (hunting_reg)
            begin
                if (pos_reg == '0)
                begin
                    first_next = rx_byte;
                    pos_next   = POS_W'(1);
                end
                else
                begin
                    pos_next       = '0;
                    out_valid_next = 1'b1;
                    if ({rx_byte, first_reg} == header_reg)
                    begin
                        hunting_next = 1'b0;
                        sum_next     = '0;
                        status_next  = STAT_HDR_OK;
                    end
                    else
                    begin
                        status_next = STAT_HDR_ERR;
                    end
                end
            end
            else if (pos_reg < POS_W'(SUM_LEN))
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                hunting_next   = 1'b1;
                pos_next       = '0;
                out_valid_next = 1'b1;
                if (rx_byte == sum_reg)
                begin
                    latch_en    = 1'b1;
                    status_next = STAT_CHK_GOOD;
                end
                else
                begin
                    status_next = STAT_CHK_ERR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RESET;
            hunting_reg   <= 1'b1;
            pos_reg       <= '0;
            first_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_HDR_OK;
            index_reg     <= '0;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                header_reg <= cfg_write_data;
            end
            hunting_reg   <= hunting_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            // Latched fields change only with a new result, so they drive the port directly.
            if (latch_en)
            begin
                index_reg <= cell_q[KEPT_LEN-1];
                yaw_reg   <= -17'(word_at(cell_q[KEPT_LEN-2], cell_q[KEPT_LEN-3]));
                roll_reg  <= word_at(cell_q[KEPT_LEN-4], cell_q[KEPT_LEN-5]);
                pitch_reg <= word_at(cell_q[KEPT_LEN-6], cell_q[KEPT_LEN-7]);
                ax_reg    <= word_at(cell_q[KEPT_LEN-8], cell_q[KEPT_LEN-9]);
                ay_reg    <= word_at(cell_q[KEPT_LEN-10], cell_q[KEPT_LEN-11]);
                az_reg    <= word_at(cell_q[KEPT_LEN-12], cell_q[KEPT_LEN-13]);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign frame_index = index_reg;
    assign yaw_out     = yaw_reg;
    assign pitch_out   = pitch_reg;
    assign roll_out    = roll_reg;
    assign accel_x_out = ax_reg;
    assign accel_y_out = ay_reg;
    assign accel_z_out = az_reg;

endmodule

FILE: src/imu_ufr_cell.sv
// One byte cell of the payload shift line.
// Depends on imu_ufr_pkg for the byte width.
module imu_ufr_cell
    import imu_ufr_pkg::*;
(
    input  logic              clk,
    input  logic              shift,
    input  logic [BYTE_W-1:0] d,
    output logic [BYTE_W-1:0] q
);

    logic [BYTE_W-1:0] data_reg;

    // Take the byte on d on each shift, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

FILE: src/imu_ufr_checker.sv
// Port-level checks for the IMU serial frame receiver, bound to the top level.
// Depends on imu_ufr_pkg for the status codes.
module imu_ufr_checker
    import imu_ufr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_stall,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           status,
    input  logic [7:0]           frame_index,
    input  logic signed [16:0]   yaw_out,
    input  logic signed [15:0]   pitch_out,
    input  logic signed [15:0]   roll_out,
    input  logic signed [15:0]   accel_x_out,
    input  logic signed [15:0]   accel_y_out,
    input  logic signed [15:0]   accel_z_out
);

    // A stalled result holds its status.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    // Input backs up only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no waiting result");

    // Latched frame fields move only together with a good-checksum result.
    a_latch_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(frame_index) || !$stable(yaw_out) || !$stable(pitch_out) ||
        !$stable(roll_out) || !$stable(accel_x_out) || !$stable(accel_y_out) ||
        !$stable(accel_z_out)
        |-> out_valid && status == STAT_CHK_GOOD)
        else $error("frame fields changed without a good frame");

    // A matched header is followed by payload bytes; the next result is a checksum result.
    a_hdr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && status == STAT_HDR_OK
        |=> !out_valid || status == STAT_CHK_GOOD || status == STAT_CHK_ERR)
        else $error("header result followed by another header result");

endmodule

bind imu_uart_frame_receiver imu_ufr_checker u_imu_ufr_checker (.*);

FILE: test/imu_uart_frame_receiver_test.sv
// Self-checking testbench for imu_uart_frame_receiver: a directed byte table, then random
// well-formed, broken and noisy frames under several header settings.
// Depends on imu_ufr_pkg and the receiver RTL; needs no files or arguments.
module imu_uart_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_ufr_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 64;

    typedef struct packed {
        status_t            status;
        logic [7:0]         index;
        logic signed [16:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } frame_report_t;

    typedef enum logic [1:0] { ROW_BYTE, ROW_SUM_OK, ROW_SUM_BAD } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [7:0]    data;
        logic          typed;
        frame_report_t want;
    } table_row_t;

    // yaw 0x8000 negates to +32768; pitch and roll fields trade places
    localparam frame_report_t EXTREME_GOOD = '{STAT_CHK_GOOD, 8'hFF, 17'h08000, 16'h8000,
                                               16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF};

    localparam table_row_t DIRECTED_ROWS [40] = '{
        '{ROW_BYTE, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b1, '{status: STAT_HDR_ERR, default: '0}},
        '{ROW_BYTE, 8'hAA, 1'b0, '0},
        '{ROW_BYTE, 8'hAA, 1'b1, '{status: STAT_HDR_OK, default: '0}},
        // index, yaw 0x7FFF, pitch 0x8000, roll 0x7FFF, ax 0x8000, ay 0x7FFF, az 0
        '{ROW_BYTE, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0},
        // bad checksum leaves the latched fields at zero
        '{ROW_SUM_BAD, 8'h00, 1'b1, '{status: STAT_CHK_ERR, default: '0}},
        '{ROW_BYTE, 8'hAA, 1'b0, '0},
        '{ROW_BYTE, 8'hAA, 1'b1, '{status: STAT_HDR_OK, default: '0}},
        // index, yaw 0x8000, pitch 0x7FFF, roll 0x8000, ax 0x7FFF, ay 0x8000, az -1
        '{ROW_BYTE, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 1'b0, '0}, '{ROW_BYTE, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1'b0, '0}, '{ROW_BYTE, 8'h55, 1'b0, '0},
        '{ROW_BYTE, 8'hAA, 1'b0, '0},
        '{ROW_SUM_OK, 8'h00, 1'b1, EXTREME_GOOD}
    };

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_write_en   = 1'b0;
    logic [HEADER_W-1:0] cfg_write_data = '0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte        = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [1:0]          status;
    logic [7:0]          frame_index;
    logic signed [16:0]  yaw_out;
    logic signed [15:0]  pitch_out;
    logic signed [15:0]  roll_out;
    logic signed [15:0]  accel_x_out;
    logic signed [15:0]  accel_y_out;
    logic signed [15:0]  accel_z_out;

    // frame parser state, kept in step with accepted bytes
    logic [HEADER_W-1:0] hdr_expected;
    logic                hunting;
    int unsigned         pos;
    logic [7:0]          first_byte;
    logic [7:0]          body_sum;
    logic [7:0]          kept [KEPT_LEN];
    frame_report_t       last_good;

    frame_report_t       report_q [$];
    bit                  failed     = 1'b0;
    int unsigned         burst_left = 0;
    int unsigned         bytes_sent = 0;
    logic [15:0]         stall_pattern;
    int unsigned         stall_tick = 0;

    imu_uart_frame_receiver u_dut (.*);

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit parse_byte(input logic [7:0] b, output frame_report_t rep);
        logic signed [16:0] yaw_raw;
        rep = last_good;
        if (hunting)
        begin
            if (pos == 0)
            begin
                first_byte = b;
                pos = 1;
                return 1'b0;
            end
            pos = 0;
            if ({b, first_byte} == hdr_expected)
            begin
                hunting  = 1'b0;
                body_sum = '0;
                rep.status = STAT_HDR_OK;
            end
            else
                rep.status = STAT_HDR_ERR;
            return 1'b1;
        end
        if (pos < SUM_LEN)
        begin
            if (pos < KEPT_LEN)
                kept[pos] = b;
            body_sum += b;
            pos++;
            return 1'b0;
        end
        hunting = 1'b1;
        pos = 0;
        if (b == body_sum)
        begin
            yaw_raw           = $signed({kept[2], kept[1]});
            last_good.index   = kept[0];
            last_good.yaw     = -yaw_raw;
            last_good.pitch   = {kept[6], kept[5]};
            last_good.roll    = {kept[4], kept[3]};
            last_good.accel_x = {kept[8], kept[7]};
            last_good.accel_y = {kept[10], kept[9]};
            last_good.accel_z = {kept[12], kept[11]};
            rep = last_good;
            rep.status = STAT_CHK_GOOD;
        end
        else
            rep.status = STAT_CHK_ERR;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Hold the byte until accepted, then predict it; gaps come between bursts.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input frame_report_t want = '0);
        frame_report_t rep;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (parse_byte(b, rep))
            report_q.push_back(typed ? want : rep);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin
        if (stall_tick % 64 == 0)
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        out_stall <= stall_pattern[stall_tick % 16];
        stall_tick++;
    end

    always @(posedge clk)
    begin
        frame_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_q.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got status %0d",
                         $time, status);
                failed = 1'b1;
            end
            else
            begin
                want = report_q.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("frame_index", 32'(want.index), 32'(frame_index));
                check_field("yaw_out", want.yaw, yaw_out);
                check_field("pitch_out", want.pitch, pitch_out);
                check_field("roll_out", want.roll, roll_out);
                check_field("accel_x_out", want.accel_x, accel_x_out);
                check_field("accel_y_out", want.accel_y, accel_y_out);
                check_field("accel_z_out", want.accel_z, accel_z_out);
            end
        end
    end

    initial
    begin
        table_row_t          row;
        logic [7:0]          data;
        logic [HEADER_W-1:0] hdr;
        int unsigned         phase_start;

        hdr_expected = HEADER_RESET;
        hunting      = 1'b1;
        pos          = 0;
        first_byte   = '0;
        body_sum     = '0;
        last_good    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            case (row.kind)
                ROW_SUM_OK:  data = body_sum;
                ROW_SUM_BAD: data = body_sum + 8'd1;
                default:     data = row.data;
            endcase
            send_byte(data, row.typed, row.want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_and_settle();
            hdr = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
            cfg_write_en   <= 1'b1;
            cfg_write_data <= hdr;
            @(posedge clk);
            cfg_write_en   <= 1'b0;
            hdr_expected = hdr;

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                    2:
                    begin
                        // header, maybe with one bit flipped, then a cut-off body
                        hdr = hdr_expected;
                        if ($urandom_range(0, 1) == 1)
                            hdr ^= 16'h0001 << $urandom_range(0, 15);
                        send_byte(hdr[7:0]);
                        send_byte(hdr[15:8]);
                        repeat ($urandom_range(0, 15)) send_byte(pick_body_byte());
                    end
                    default:
                    begin
                        // realign to a pair boundary most of the time
                        if (hunting && pos == 1 && $urandom_range(0, 4) != 0)
                            send_byte(8'($urandom));
                        send_byte(hdr_expected[7:0]);
                        send_byte(hdr_expected[15:8]);
                        repeat (SUM_LEN) send_byte(pick_body_byte());
                        if ($urandom_range(0, 7) == 0)
                            send_byte(body_sum ^ (8'h01 << $urandom_range(0, 7)));
                        else
                            send_byte(body_sum);
                    end
                endcase
            end

            // leave a frame half collected so the next header write lands mid-frame
            if (p % 2 == 0)
            begin
                if (hunting && pos == 1)
                    send_byte(8'($urandom));
                send_byte(hdr_expected[7:0]);
                send_byte(hdr_expected[15:8]);
                repeat ($urandom_range(1, 15)) send_byte(pick_body_byte());
            end
        end

        drain_and_settle();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
src/imu_ufr_pkg.sv
src/imu_ufr_cell.sv
src/imu_uart_frame_receiver.sv
src/imu_ufr_checker.sv
test/imu_uart_frame_receiver_test.sv
